// ===== hw/rtl/eafr_pkg.sv =====
// Shared types and constants of the converter frame receiver.
package eafr_pkg;

  // Frame layout: status bytes first, then the data bytes.
  localparam int STATUS_BYTES = 3;
  localparam int DATA_LEN     = 24;
  localparam int FRAME_LEN    = STATUS_BYTES + DATA_LEN;
  localparam int POS_W        = 5;

  // Host packet framing bytes.
  localparam logic [7:0] PKT_HEAD = 8'hA0;
  localparam logic [7:0] PKT_FOOT = 8'hC0;

  // Step numbers within the host packet.
  localparam logic [5:0] PK_HEAD       = 6'd0;
  localparam logic [5:0] PK_COUNT      = 6'd1;
  localparam logic [5:0] PK_DATA_FIRST = 6'd2;
  localparam logic [5:0] PK_PAD_FIRST  = 6'd26;
  localparam logic [5:0] PK_FOOT       = 6'd32;

  // Result kinds carried in tuser.
  localparam logic [1:0] KIND_PACKET = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_SAMPLE = 2'd2;

  // Register indexes on the configuration port.
  localparam logic REG_PACKET_ENABLE = 1'b0;
  localparam logic REG_SAMPLE_ENABLE = 1'b1;

  // Control of the byte chain: shift moves every cell one place towards
  // the head; src_link feeds the tail from the link instead of the head.
  typedef struct packed {
    logic shift;
    logic src_link;
  } chain_ctrl_t;

endpackage

// ===== hw/rtl/eafr_cell.sv =====
// One byte cell of the data chain.
module eafr_cell (
  input  logic       clk,
  input  logic       en,
  input  logic [7:0] d,
  output logic [7:0] q
);

  // The cell takes its neighbour's byte whenever the chain moves.
  always_ff @(posedge clk) begin
    if (en) begin
      q <= d;
    end
  end

endmodule

// ===== hw/rtl/eafr_seq.sv =====
// Frame tracking, result sequencing and output register of the receiver.
module eafr_seq #(
  parameter int CHANNELS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          link_byte,
  input  logic                frame_start,
  input  logic                packet_enable,
  input  logic                sample_enable,
  input  logic [7:0]          head_byte,
  output eafr_pkg::chain_ctrl_t ctrl,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [1:0]          kind,
  output logic [7:0]          packet_byte,
  output logic [23:0]         status_word,
  output logic [2:0]          channel_index,
  output logic [23:0]         sample_value,
  output logic                last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PKT  = 2'd1;
  localparam logic [1:0] ST_STAT = 2'd2;
  localparam logic [1:0] ST_SAMP = 2'd3;
  localparam logic [2:0] LAST_CHAN = 3'(CHANNELS - 1);

  logic [1:0]                 state, state_next;
  logic [eafr_pkg::POS_W-1:0] pos, pos_next, pos_eff;
  logic [5:0]                 pk, pk_next;
  logic [1:0]                 bsel, bsel_next;
  logic [2:0]                 chan, chan_next;
  logic [15:0]                acc, acc_next;
  logic [23:0]                status, status_next;
  logic [7:0]                 counter, counter_next;
  logic                       adv, emit, load, rot;
  logic [1:0]                 e_kind;
  logic [7:0]                 e_pb;
  logic [23:0]                e_sw;
  logic [2:0]                 e_ch;
  logic [23:0]                e_sv;
  logic                       e_last;

  // Input bytes are taken only while no frame is being reported.
  assign s_tready = (state == ST_IDLE);
  // The output register can take a new result when empty or being drained.
  assign adv = !m_tvalid || m_tready;
  assign pos_eff = frame_start ? '0 : pos;

  assign ctrl.shift    = load || rot;
  assign ctrl.src_link = load;

  // Next-state logic of the frame tracker and the result sequencer.
  always_comb begin
    state_next   = state;
    pos_next     = pos;
    pk_next      = pk;
    bsel_next    = bsel;
    chan_next    = chan;
    acc_next     = acc;
    status_next  = status;
    counter_next = counter;
    emit   = 1'b0;
    load   = 1'b0;
    rot    = 1'b0;
    e_kind = eafr_pkg::KIND_PACKET;
    e_pb   = '0;
    e_sw   = '0;
    e_ch   = '0;
    e_sv   = '0;
    e_last = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid && (pos_eff < eafr_pkg::POS_W'(eafr_pkg::FRAME_LEN))) begin
          if (pos_eff < eafr_pkg::POS_W'(eafr_pkg::STATUS_BYTES)) begin
            status_next = {status[15:0], link_byte};
          end else begin
            load = 1'b1;
          end
          pos_next = pos_eff + 1'b1;
          if (pos_eff == eafr_pkg::POS_W'(eafr_pkg::FRAME_LEN - 1)) begin
            counter_next = counter + 1'b1;
            pk_next      = eafr_pkg::PK_HEAD;
            if (packet_enable) begin
              state_next = ST_PKT;
            end else if (sample_enable) begin
              state_next = ST_STAT;
            end
          end
        end
      end
      ST_PKT: begin
        if (adv) begin
          emit    = 1'b1;
          pk_next = pk + 1'b1;
          if (pk == eafr_pkg::PK_HEAD) begin
            e_pb = eafr_pkg::PKT_HEAD;
          end else if (pk == eafr_pkg::PK_COUNT) begin
            e_pb = counter;
          end else if (pk < eafr_pkg::PK_PAD_FIRST) begin
            // Data bytes leave from the head and re-enter at the tail.
            e_pb = head_byte;
            rot  = 1'b1;
          end else if (pk == eafr_pkg::PK_FOOT) begin
            e_pb    = eafr_pkg::PKT_FOOT;
            e_last  = !sample_enable;
            pk_next = eafr_pkg::PK_HEAD;
            state_next = sample_enable ? ST_STAT : ST_IDLE;
          end
        end
      end
      ST_STAT: begin
        if (adv) begin
          emit       = 1'b1;
          e_kind     = eafr_pkg::KIND_STATUS;
          e_sw       = status;
          bsel_next  = '0;
          chan_next  = '0;
          state_next = ST_SAMP;
        end
      end
      ST_SAMP: begin
        // Two bytes are gathered, the third completes the sample.
        if (bsel != 2'd2) begin
          acc_next  = {acc[7:0], head_byte};
          rot       = 1'b1;
          bsel_next = bsel + 1'b1;
        end else if (adv) begin
          emit      = 1'b1;
          rot       = 1'b1;
          e_kind    = eafr_pkg::KIND_SAMPLE;
          e_ch      = chan;
          e_sv      = {acc, head_byte};
          e_last    = (chan == LAST_CHAN);
          bsel_next = '0;
          chan_next = chan + 1'b1;
          if (chan == LAST_CHAN) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control and frame state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pos      <= eafr_pkg::POS_W'(eafr_pkg::FRAME_LEN);
      pk       <= eafr_pkg::PK_HEAD;
      bsel     <= '0;
      chan     <= '0;
      counter  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      pos     <= pos_next;
      pk      <= pk_next;
      bsel    <= bsel_next;
      chan    <= chan_next;
      counter <= counter_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    acc    <= acc_next;
    status <= status_next;
    if (emit) begin
      kind          <= e_kind;
      packet_byte   <= e_pb;
      status_word   <= e_sw;
      channel_index <= e_ch;
      sample_value  <= e_sv;
      last          <= e_last;
    end
  end

`ifndef NO_ASSERTIONS
  // The packet step counter never runs past the footer.
  a_pk_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PKT) |-> (pk <= eafr_pkg::PK_FOOT))
    else $error("packet step out of range");

  // The byte gatherer never reaches a fourth byte.
  a_bsel_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SAMP) |-> (bsel != 2'd3))
    else $error("sample byte select out of range");

  // The final result of a frame returns the sequencer to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (emit && e_last) |=> (state == ST_IDLE))
    else $error("sequencer busy after final result");

  // Link bytes enter the chain only while idle, never during readout.
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.src_link |-> (state == ST_IDLE) && !rot)
    else $error("chain loaded during readout");

  // With both modes off a frame end leaves the block idle.
  a_quiet_end: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !packet_enable && !sample_enable) |=> (state == ST_IDLE))
    else $error("result sequence started with both modes off");
`endif

endmodule

// ===== hw/rtl/eeg_adc_frame_receiver.sv =====
// Top level of the converter frame receiver: configuration, byte chain, sequencer.
//
// The block takes a converter frame one byte per transfer on the s_ channel
// (tdata = link byte, tuser = start mark). A frame is 3 status bytes and
// 24 data bytes; bytes beyond the 27th are dropped until the next start mark,
// and a start mark in mid-frame restarts the frame.
// The data bytes are held in a chain of 24 byte cells; a byte enters at the
// tail and every cell passes its byte to its neighbour with each data byte.
// At frame end the 8-bit frame counter increments. With packet_enable set,
// 33 packet bytes follow on the m_ channel, the data bytes rotating once
// round the chain, one per cycle while m_tready does not hold the output.
// With sample_enable set, the status word and CHANNELS samples follow; each
// sample is gathered from three bytes of chain rotation. After the last byte
// is taken the sequencer leaves idle and loads the first result into the
// output register. After the last byte of a frame s_tready stays low while
// the enabled outputs are sent; while m_tready is low a waiting result sits
// in the output register and the sequencer holds until it is taken.
// Reset clears both modes, the counter and the frame position (idle,
// waiting for a start mark). Configuration is written over the APB port.
module eeg_adc_frame_receiver #(
  parameter int CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input byte stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] link_byte
  input  logic        s_tuser,   // [0] frame_start
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] packet_byte, [31:8] status_word, [34:32] channel_index,
  // [58:35] sample_value, [63:59] zero
  output logic [63:0] m_tdata,
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast    // last
);

  logic                  packet_enable, sample_enable;
  logic                  reg_sel;
  eafr_pkg::chain_ctrl_t ctrl;
  logic [7:0]            cells [eafr_pkg::DATA_LEN];
  logic [7:0]            tail_in;
  logic [7:0]            packet_byte;
  logic [23:0]           status_word;
  logic [2:0]            channel_index;
  logic [23:0]           sample_value;

  // Configuration registers: index from the word address.
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_enable <= 1'b0;
      sample_enable <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      if (reg_sel == eafr_pkg::REG_PACKET_ENABLE) begin
        packet_enable <= pwdata[0];
      end else begin
        sample_enable <= pwdata[0];
      end
    end
  end

  assign prdata = {31'd0, (reg_sel == eafr_pkg::REG_SAMPLE_ENABLE) ? sample_enable
                                                                   : packet_enable};

  // Row of byte cells; the tail takes a link byte or the head byte.
  assign tail_in = ctrl.src_link ? s_tdata : cells[0];

  for (genvar i = 0; i < eafr_pkg::DATA_LEN; i++) begin : g_cell
    if (i == eafr_pkg::DATA_LEN - 1) begin : g_tail
      eafr_cell u_cell (.clk(clk), .en(ctrl.shift), .d(tail_in), .q(cells[i]));
    end else begin : g_body
      eafr_cell u_cell (.clk(clk), .en(ctrl.shift), .d(cells[i+1]), .q(cells[i]));
    end
  end

  // Frame tracking and result sequencing.
  eafr_seq #(.CHANNELS(CHANNELS)) u_seq (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .link_byte     (s_tdata),
    .frame_start   (s_tuser),
    .packet_enable (packet_enable),
    .sample_enable (sample_enable),
    .head_byte     (cells[0]),
    .ctrl          (ctrl),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .kind          (m_tuser),
    .packet_byte   (packet_byte),
    .status_word   (status_word),
    .channel_index (channel_index),
    .sample_value  (sample_value),
    .last          (m_tlast)
  );

  assign m_tdata = {5'd0, sample_value, channel_index, status_word, packet_byte};

endmodule
